FILE: hw/rtl/wjsr_pkg.sv
// Shared types, constants and pointer helpers for the journal slot ring.
`default_nettype none

package wjsr_pkg;

    localparam int SLOT_COUNT = 2048;
    localparam int BLOCK_BITS = 48;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int ID_W       = 32;
    localparam int KIND_W     = 2;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;

    typedef enum logic [2:0] {
        MODE_ALLOC   = 3'd0,
        MODE_APPEND  = 3'd1,
        MODE_DQUERY  = 3'd2,
        MODE_DEMOTE  = 3'd3,
        MODE_NEXT_WB = 3'd4,
        MODE_COMMIT  = 3'd5,
        MODE_PENDING = 3'd6,
        MODE_LOCATE  = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_SLOT = 2'd1,
        STAT_NO_DATA = 2'd2,
        STAT_BUSY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        SLOT_ALLOC = 3'd1,
        SLOT_VALID = 3'd2,
        SLOT_WB    = 3'd3,
        SLOT_DONE  = 3'd4
    } slot_state_t;

    typedef struct packed {
        logic              wrap;
        logic [SLOT_W-1:0] idx;
    } ptr_t;

    typedef struct packed {
        mode_t                 mode;
        logic [ID_W-1:0]       id;
        logic [BLOCK_BITS-1:0] blk;
        logic [KIND_W-1:0]     kind;
        logic                  grant;
    } op_t;

    typedef struct packed {
        status_t               status;
        logic [ID_W-1:0]       id;
        logic [BLOCK_BITS-1:0] blk;
        logic [KIND_W-1:0]     kind;
        logic                  demoted;
        logic [SLOT_W-1:0]     slot;
        logic                  flag;
    } res_t;

    typedef struct packed {
        slot_state_t           state;
        logic [ID_W-1:0]       id;
        logic [BLOCK_BITS-1:0] blk;
        logic [KIND_W-1:0]     kind;
        logic                  demoted;
    } slot_t;

    typedef struct packed {
        logic                  valid;
        logic [BLOCK_BITS-1:0] key;
        logic [ID_W-1:0]       id;
    } map_t;

    function automatic ptr_t ptr_adv(ptr_t p);
        ptr_t r;
        r = p;
        if (p.idx == SLOT_W'(SLOT_COUNT - 1))
        begin
            r.idx  = '0;
            r.wrap = ~p.wrap;
        end
        else
        begin
            r.idx = p.idx + SLOT_W'(1);
        end
        return r;
    endfunction

    // Number of slots from the tail pointer up to the head pointer.
    function automatic logic [CNT_W-1:0] ptr_dist(ptr_t head, ptr_t tail);
        logic [CNT_W-1:0] d;
        if (head.wrap == tail.wrap)
            d = CNT_W'(head.idx) - CNT_W'(tail.idx);
        else
            d = CNT_W'(SLOT_COUNT) - CNT_W'(tail.idx) + CNT_W'(head.idx);
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/writeback_journal_slot_ring.sv
// Top level of the journal slot ring: request queue front end and execution engine.
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------------
//  request | in_valid / in_stall     | mode event_id block_number access_kind
//          |                         | guard_granted
//  result  | out_valid / out_stall   | status out_id out_block out_kind out_demoted
//          |                         | slot_index answer_flag
//
// Allocate, pending, locate and failed id lookups finish in the find step; writeback adds a slot read.
// Append scans the block map RAM one entry a cycle;
// demote query and demote with a live mapping add a slot read after the scan.
// Commit reads its slot, scans the map, then reads slots one by one in the retire walk.
// After reset the block map RAM is cleared entry by entry before the first
// item runs; a two-entry request queue accepts items meanwhile and under output stall.
`default_nettype none

module writeback_journal_slot_ring (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [2:0]                         mode,
    input  wire logic [wjsr_pkg::ID_W-1:0]          event_id,
    input  wire logic [wjsr_pkg::BLOCK_BITS-1:0]    block_number,
    input  wire logic [wjsr_pkg::KIND_W-1:0]        access_kind,
    input  wire logic                               guard_granted,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [1:0]                              status,
    output logic [wjsr_pkg::ID_W-1:0]               out_id,
    output logic [wjsr_pkg::BLOCK_BITS-1:0]         out_block,
    output logic [wjsr_pkg::KIND_W-1:0]             out_kind,
    output logic                                    out_demoted,
    output logic [wjsr_pkg::SLOT_W-1:0]             slot_index,
    output logic                                    answer_flag
);

    logic           q_valid;
    logic           q_pop;
    wjsr_pkg::op_t  q_op;
    wjsr_pkg::res_t res;

    wjsr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .event_id      (event_id),
        .block_number  (block_number),
        .access_kind   (access_kind),
        .guard_granted (guard_granted),
        .q_valid       (q_valid),
        .q_op          (q_op),
        .q_pop         (q_pop)
    );

    wjsr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign status      = res.status;
    assign out_id      = res.id;
    assign out_block   = res.blk;
    assign out_kind    = res.kind;
    assign out_demoted = res.demoted;
    assign slot_index  = res.slot;
    assign answer_flag = res.flag;

endmodule

`default_nettype wire

FILE: hw/rtl/wjsr_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module wjsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wjsr_front.sv
// Front end: accepts request items, decodes them and queues them for the engine.
`default_nettype none

module wjsr_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [2:0]                         mode,
    input  wire logic [wjsr_pkg::ID_W-1:0]          event_id,
    input  wire logic [wjsr_pkg::BLOCK_BITS-1:0]    block_number,
    input  wire logic [wjsr_pkg::KIND_W-1:0]        access_kind,
    input  wire logic                               guard_granted,
    output logic                                    q_valid,
    output wjsr_pkg::op_t                           q_op,
    input  wire logic                               q_pop
);

    wjsr_pkg::op_t q_mem_reg [2];
    logic [1:0]    count_reg;
    logic          wr_reg;
    logic          rd_reg;
    wjsr_pkg::op_t op_in;
    logic          push;

    always_comb
    begin
        op_in.mode  = wjsr_pkg::mode_t'(mode);
        op_in.id    = event_id;
        op_in.blk   = block_number;
        op_in.kind  = access_kind;
        // The guard only matters to a writeback request; drop it elsewhere.
        op_in.grant = guard_granted && (wjsr_pkg::mode_t'(mode) == wjsr_pkg::MODE_NEXT_WB);
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_op     = q_mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                q_mem_reg[wr_reg] <= op_in;
                wr_reg            <= ~wr_reg;
            end
            if (q_pop)
                rd_reg <= ~rd_reg;
            if (push && !q_pop)
                count_reg <= count_reg + 2'd1;
            else if (!push && q_pop)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wjsr_back.sv
// Back end: executes queued requests against the slot ring and the block map.
`default_nettype none

module wjsr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire wjsr_pkg::op_t q_op,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output wjsr_pkg::res_t     res
);

    localparam int SLOT_COUNT = wjsr_pkg::SLOT_COUNT;
    localparam int SLOT_W     = wjsr_pkg::SLOT_W;
    localparam int CNT_W      = wjsr_pkg::CNT_W;
    localparam int ID_W       = wjsr_pkg::ID_W;
    localparam int SUM_W      = SLOT_W + 1;
    localparam int SLOT_BITS  = $bits(wjsr_pkg::slot_t);
    localparam int MAP_BITS   = $bits(wjsr_pkg::map_t);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_MAPDONE,
        S_FIND2,
        S_RD_WAIT,
        S_RD_USE,
        S_WALK,
        S_WALK_WAIT,
        S_WALK_CHK
    } state_t;

    state_t                             state_reg;
    wjsr_pkg::op_t                      op_reg;
    wjsr_pkg::res_t                     res_reg;
    logic                               out_valid_reg;
    wjsr_pkg::ptr_t                     alloc_reg;
    wjsr_pkg::ptr_t                     wb_reg;
    wjsr_pkg::ptr_t                     commit_reg;
    logic [ID_W-1:0]                    last_id_reg;
    logic [SLOT_W-1:0]                  fslot_reg;
    logic [wjsr_pkg::BLOCK_BITS-1:0]    scan_key_reg;
    logic [SLOT_W-1:0]                  scan_idx_reg;
    logic [SLOT_W-1:0]                  chk_idx_reg;
    logic                               chk_vld_reg;
    logic                               map_hit_reg;
    logic [SLOT_W-1:0]                  map_idx_reg;
    logic [ID_W-1:0]                    map_id_reg;
    logic                               free_found_reg;
    logic [SLOT_W-1:0]                  free_idx_reg;
    wjsr_pkg::slot_t                    slot_word_reg;
    logic [SLOT_W-1:0]                  clr_idx_reg;

    logic                               slot_we_reg;
    logic [SLOT_W-1:0]                  slot_waddr_reg;
    wjsr_pkg::slot_t                    slot_wdata_reg;
    logic [SLOT_W-1:0]                  slot_raddr_reg;
    logic [SLOT_BITS-1:0]               slot_rdata;
    logic                               map_we_reg;
    logic [SLOT_W-1:0]                  map_waddr_reg;
    wjsr_pkg::map_t                     map_wdata_reg;
    logic [MAP_BITS-1:0]                map_rdata;

    wjsr_pkg::slot_t                    slot_rword;
    wjsr_pkg::map_t                     map_rword;
    logic [CNT_W-1:0]                   live;
    logic [ID_W-1:0]                    lookup_id;
    logic [ID_W-1:0]                    k;
    logic [SUM_W-1:0]                   sum;
    logic                               fhit;
    logic [SLOT_W-1:0]                  fslot;

    function automatic wjsr_pkg::slot_t fresh_slot(logic [ID_W-1:0] id);
        wjsr_pkg::slot_t r;
        r       = '0;
        r.state = wjsr_pkg::SLOT_ALLOC;
        r.id    = id;
        return r;
    endfunction

    function automatic wjsr_pkg::slot_t with_state(wjsr_pkg::slot_t w,
                                                   wjsr_pkg::slot_state_t s);
        wjsr_pkg::slot_t r;
        r       = w;
        r.state = s;
        return r;
    endfunction

    function automatic wjsr_pkg::slot_t with_demoted(wjsr_pkg::slot_t w);
        wjsr_pkg::slot_t r;
        r         = w;
        r.demoted = 1'b1;
        return r;
    endfunction

    wjsr_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOT_COUNT)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we_reg),
        .waddr (slot_waddr_reg),
        .wdata (slot_wdata_reg),
        .raddr (slot_raddr_reg),
        .rdata (slot_rdata)
    );

    wjsr_ram #(.WIDTH(MAP_BITS), .DEPTH(SLOT_COUNT)) u_map_ram (
        .clk   (clk),
        .we    (map_we_reg),
        .waddr (map_waddr_reg),
        .wdata (map_wdata_reg),
        .raddr (scan_idx_reg),
        .rdata (map_rdata)
    );

    // Live slots form the ring range from the commit pointer to the allocate
    // pointer and carry consecutive ids, so an id maps to a slot by offset.
    always_comb
    begin
        slot_rword = wjsr_pkg::slot_t'(slot_rdata);
        map_rword  = wjsr_pkg::map_t'(map_rdata);
        live       = wjsr_pkg::ptr_dist(alloc_reg, commit_reg);
        lookup_id  = (state_reg == S_FIND2) ? map_id_reg : op_reg.id;
        k          = lookup_id - last_id_reg + ID_W'(live) - ID_W'(1);
        fhit       = (k < ID_W'(live));
        sum        = {1'b0, commit_reg.idx} + k[SUM_W-1:0];
        if (sum >= SUM_W'(SLOT_COUNT))
            fslot = SLOT_W'(sum - SUM_W'(SLOT_COUNT));
        else
            fslot = sum[SLOT_W-1:0];
    end

    assign q_pop     = (state_reg == S_IDLE) && q_valid && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic slot_we_set;
        logic map_we_set;
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            alloc_reg     <= '0;
            wb_reg        <= '0;
            commit_reg    <= '0;
            last_id_reg   <= '0;
            slot_we_reg   <= 1'b0;
            map_we_reg    <= 1'b0;
            clr_idx_reg   <= '0;
            chk_vld_reg   <= 1'b0;
        end
        else
        begin
            slot_we_set = 1'b0;
            map_we_set  = 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                begin
                    map_we_set     = 1'b1;
                    map_waddr_reg <= clr_idx_reg;
                    map_wdata_reg <= '0;
                    if (clr_idx_reg == LAST_IDX)
                        state_reg <= S_IDLE;
                    else
                        clr_idx_reg <= clr_idx_reg + SLOT_W'(1);
                end

                S_IDLE:
                begin
                    if (q_valid && !out_valid_reg)
                    begin
                        op_reg    <= q_op;
                        res_reg   <= '0;
                        state_reg <= S_FIND;
                    end
                end

                S_FIND:
                begin
                    case (op_reg.mode)
                        wjsr_pkg::MODE_ALLOC:
                        begin
                            if (live == CNT_W'(SLOT_COUNT))
                            begin
                                res_reg.status <= wjsr_pkg::STAT_NO_SLOT;
                            end
                            else
                            begin
                                slot_we_set             = 1'b1;
                                slot_waddr_reg         <= alloc_reg.idx;
                                slot_wdata_reg         <= fresh_slot(last_id_reg + ID_W'(1));
                                last_id_reg            <= last_id_reg + ID_W'(1);
                                alloc_reg              <= wjsr_pkg::ptr_adv(alloc_reg);
                                res_reg.id             <= last_id_reg + ID_W'(1);
                                res_reg.slot           <= alloc_reg.idx;
                            end
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        wjsr_pkg::MODE_APPEND,
                        wjsr_pkg::MODE_DQUERY,
                        wjsr_pkg::MODE_DEMOTE:
                        begin
                            if (op_reg.mode == wjsr_pkg::MODE_APPEND && !fhit)
                            begin
                                res_reg.status <= wjsr_pkg::STAT_NO_DATA;
                                out_valid_reg  <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                fslot_reg      <= fslot;
                                scan_key_reg   <= op_reg.blk;
                                scan_idx_reg   <= '0;
                                chk_vld_reg    <= 1'b0;
                                map_hit_reg    <= 1'b0;
                                free_found_reg <= 1'b0;
                                state_reg      <= S_SCAN;
                            end
                        end
                        wjsr_pkg::MODE_NEXT_WB:
                        begin
                            if (wb_reg == alloc_reg)
                            begin
                                res_reg.status <= wjsr_pkg::STAT_NO_DATA;
                                out_valid_reg  <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                slot_raddr_reg <= wb_reg.idx;
                                fslot_reg      <= wb_reg.idx;
                                state_reg      <= S_RD_WAIT;
                            end
                        end
                        wjsr_pkg::MODE_COMMIT:
                        begin
                            if (!fhit)
                            begin
                                res_reg.status <= wjsr_pkg::STAT_NO_DATA;
                                out_valid_reg  <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                slot_raddr_reg <= fslot;
                                fslot_reg      <= fslot;
                                state_reg      <= S_RD_WAIT;
                            end
                        end
                        wjsr_pkg::MODE_PENDING:
                        begin
                            res_reg.flag  <= (wb_reg != alloc_reg) && (commit_reg == wb_reg);
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        default:
                        begin
                            if (fhit)
                                res_reg.slot <= fslot;
                            else
                                res_reg.status <= wjsr_pkg::STAT_NO_DATA;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    endcase
                end

                // One map entry is read per cycle; the compare checks the entry read
                // for the previous address, held in chk_idx_reg.
                S_SCAN:
                begin
                    chk_vld_reg <= 1'b1;
                    chk_idx_reg <= scan_idx_reg;
                    if (scan_idx_reg != LAST_IDX)
                        scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
                    if (chk_vld_reg)
                    begin
                        if (map_rword.valid && map_rword.key == scan_key_reg)
                        begin
                            map_hit_reg <= 1'b1;
                            map_idx_reg <= chk_idx_reg;
                            map_id_reg  <= map_rword.id;
                            state_reg   <= S_MAPDONE;
                        end
                        else
                        begin
                            if (!map_rword.valid && !free_found_reg)
                            begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= chk_idx_reg;
                            end
                            if (chk_idx_reg == LAST_IDX)
                                state_reg <= S_MAPDONE;
                        end
                    end
                end

                S_MAPDONE:
                begin
                    case (op_reg.mode)
                        wjsr_pkg::MODE_APPEND:
                        begin
                            if (map_hit_reg || free_found_reg)
                            begin
                                map_we_set             = 1'b1;
                                map_waddr_reg         <= map_hit_reg ? map_idx_reg
                                                                     : free_idx_reg;
                                map_wdata_reg.valid   <= 1'b1;
                                map_wdata_reg.key     <= op_reg.blk;
                                map_wdata_reg.id      <= op_reg.id;
                                slot_we_set            = 1'b1;
                                slot_waddr_reg        <= fslot_reg;
                                slot_wdata_reg.state  <= wjsr_pkg::SLOT_VALID;
                                slot_wdata_reg.id     <= op_reg.id;
                                slot_wdata_reg.blk    <= op_reg.blk;
                                slot_wdata_reg.kind   <= op_reg.kind;
                                slot_wdata_reg.demoted <= 1'b0;
                                res_reg.slot          <= fslot_reg;
                            end
                            else
                            begin
                                res_reg.status <= wjsr_pkg::STAT_NO_SLOT;
                            end
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        wjsr_pkg::MODE_DQUERY,
                        wjsr_pkg::MODE_DEMOTE:
                        begin
                            if (map_hit_reg)
                            begin
                                state_reg <= S_FIND2;
                            end
                            else
                            begin
                                if (op_reg.mode == wjsr_pkg::MODE_DEMOTE)
                                    res_reg.status <= wjsr_pkg::STAT_NO_DATA;
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                        end
                        default:
                        begin
                            // Commit: drop the mapping only if it still names this id.
                            if (map_hit_reg && map_id_reg == op_reg.id)
                            begin
                                map_we_set     = 1'b1;
                                map_waddr_reg <= map_idx_reg;
                                map_wdata_reg <= '0;
                            end
                            slot_we_set           = 1'b1;
                            slot_waddr_reg       <= fslot_reg;
                            slot_wdata_reg       <= with_state(slot_word_reg,
                                                               wjsr_pkg::SLOT_DONE);
                            res_reg.slot         <= fslot_reg;
                            state_reg            <= S_WALK;
                        end
                    endcase
                end

                S_FIND2:
                begin
                    if (fhit)
                    begin
                        slot_raddr_reg <= fslot;
                        fslot_reg      <= fslot;
                        state_reg      <= S_RD_WAIT;
                    end
                    else
                    begin
                        if (op_reg.mode == wjsr_pkg::MODE_DEMOTE)
                            res_reg.status <= wjsr_pkg::STAT_NO_DATA;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                S_RD_WAIT:
                begin
                    state_reg <= S_RD_USE;
                end

                S_RD_USE:
                begin
                    case (op_reg.mode)
                        wjsr_pkg::MODE_NEXT_WB:
                        begin
                            if (slot_rword.state != wjsr_pkg::SLOT_VALID)
                            begin
                                res_reg.status <= wjsr_pkg::STAT_NO_DATA;
                            end
                            else if (!op_reg.grant)
                            begin
                                res_reg.status <= wjsr_pkg::STAT_BUSY;
                            end
                            else
                            begin
                                slot_we_set           = 1'b1;
                                slot_waddr_reg       <= fslot_reg;
                                slot_wdata_reg       <= with_state(slot_rword,
                                                                   wjsr_pkg::SLOT_WB);
                                wb_reg               <= wjsr_pkg::ptr_adv(wb_reg);
                                res_reg.id           <= slot_rword.id;
                                res_reg.blk          <= slot_rword.blk;
                                res_reg.kind         <= slot_rword.kind;
                                res_reg.demoted      <= slot_rword.demoted;
                                res_reg.slot         <= fslot_reg;
                            end
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        wjsr_pkg::MODE_COMMIT:
                        begin
                            slot_word_reg  <= slot_rword;
                            scan_key_reg   <= slot_rword.blk;
                            scan_idx_reg   <= '0;
                            chk_vld_reg    <= 1'b0;
                            map_hit_reg    <= 1'b0;
                            free_found_reg <= 1'b0;
                            state_reg      <= S_SCAN;
                        end
                        wjsr_pkg::MODE_DQUERY:
                        begin
                            res_reg.flag  <= (slot_rword.kind == wjsr_pkg::KIND_WRITE);
                            res_reg.slot  <= fslot_reg;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        default:
                        begin
                            if (slot_rword.kind != wjsr_pkg::KIND_WRITE)
                            begin
                                res_reg.status <= wjsr_pkg::STAT_NO_DATA;
                            end
                            else
                            begin
                                slot_we_set             = 1'b1;
                                slot_waddr_reg         <= fslot_reg;
                                slot_wdata_reg         <= with_demoted(slot_rword);
                                res_reg.slot           <= fslot_reg;
                            end
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    endcase
                end

                // Retire committed slots in order, stopping at the writeback pointer or at the first slot not yet done.
                S_WALK:
                begin
                    if (commit_reg == wb_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        slot_raddr_reg <= commit_reg.idx;
                        state_reg      <= S_WALK_WAIT;
                    end
                end

                S_WALK_WAIT:
                begin
                    state_reg <= S_WALK_CHK;
                end

                S_WALK_CHK:
                begin
                    if (slot_rword.state == wjsr_pkg::SLOT_DONE)
                    begin
                        commit_reg <= wjsr_pkg::ptr_adv(commit_reg);
                        state_reg  <= S_WALK;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            slot_we_reg <= slot_we_set;
            map_we_reg  <= map_we_set;
        end
    end

endmodule

`default_nettype wire
